FILE: rtl/mhq_pkg.sv
// shared types and constants of the mesh hop latency delivery queue
package mhq_pkg;

   localparam int OUT_LIMIT = 16;
   localparam int N_W       = 5;
   localparam int LMAX_SAT  = 8191;

   localparam logic [1:0] KIND_INJECT  = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_IDLE    = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] REG_COLS     = 2'd0;
   localparam logic [1:0] REG_ROWS     = 2'd1;
   localparam logic [1:0] REG_HOP_LAT  = 2'd2;

   typedef struct packed {
      logic [15:0] tile_id;
      logic [31:0] tile_size;
      logic [7:0]  src;
      logic [7:0]  dst;
      logic [47:0] sent_at;
      logic [48:0] due_at;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      entry_type   entry;
      logic [31:0] delivered;
      logic [63:0] latency_total;
      logic [12:0] latency_max;
      logic        last;
   } rsp_type;

endpackage

FILE: rtl/mhq_cell.sv
// one queue slot of the packed delivery queue chain
module mhq_cell
   import mhq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    wr_data,
   input  entry_type    up_data,
   input  logic         up_valid,
   output entry_type    data,
   output logic         valid
);

   entry_type data_ff;
   logic      valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= wr_data;
      end else if (ctl.shift) begin
         data_ff <= up_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= 1'b1;
      end else if (ctl.shift) begin
         valid_ff <= up_valid;
      end
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

FILE: rtl/mhq_div.sv
// restoring divider, router index by column count, one quotient bit per cycle
module mhq_div
   import mhq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] dividend,
   input  logic [4:0] divisor,
   output logic       busy,
   output logic [7:0] quotient,
   output logic [4:0] remainder
);

   logic [7:0] q_ff;
   logic [4:0] r_ff;
   logic [4:0] d_ff;
   logic [2:0] cnt_ff;
   logic       busy_ff;
   logic [5:0] trial;
   logic       take;
   logic [4:0] r_in;

   assign trial = {r_ff, q_ff[7]};
   assign take  = trial >= {1'b0, d_ff};
   assign r_in  = take ? 5'(trial - {1'b0, d_ff}) : trial[4:0];

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         q_ff <= {q_ff[6:0], take};
         r_ff <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy      = busy_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

FILE: rtl/mesh_hop_latency_delivery_queue_unit.sv
// top level: mesh hop latency model with a packed delivery queue
// An inject beat runs the iterative row/column divider, then the hop multiply, the
// deliver-cycle add and the queue write. A tick beat scans the queue chain one slot
// a cycle to find the earliest ready tile, so each delivered tile costs a fresh scan
// of the queued entries, and so does a tick that finds tiles queued but none ready.
// Results leave through an output register, so the next request beat is taken while
// the last result of the previous one still waits. Up to 16 tiles leave per tick.
module mesh_hop_latency_delivery_queue_unit
   import mhq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [111:0]   req_tdata,  // src, dst, tile_id, tile_size, now_cycle
   input  logic           req_tuser,  // action
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // status, out_tile_id, out_tile_size, out_src, out_dst, sent_at,
   // due_at, delivered_count, latency_total, latency_max
   output logic [271:0]   rsp_tdata,
   output logic [1:0]     rsp_tuser,  // result_kind
   output logic           rsp_tlast,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [1:0]     csr_index,
   input  logic [7:0]     csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DIV     = 3'd1;
   localparam logic [2:0] S_MUL     = 3'd2;
   localparam logic [2:0] S_ADD     = 3'd3;
   localparam logic [2:0] S_SCAN    = 3'd4;
   localparam logic [2:0] S_DECIDE  = 3'd5;
   localparam logic [2:0] S_CAPTURE = 3'd6;
   localparam logic [2:0] S_EMIT    = 3'd7;

   logic [2:0]       state_ff;
   logic [2:0]       emit_next_ff;
   logic [4:0]       cols_ff;
   logic [4:0]       rows_ff;
   logic [7:0]       hop_lat_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] scan_idx_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic             best_found_ff;
   entry_type        best_ff;
   logic [N_W-1:0]   n_ff;
   logic [31:0]      stat_del_ff;
   logic [63:0]      stat_sum_ff;
   logic [12:0]      stat_max_ff;
   rsp_type          stage_ff;
   logic             stage_valid_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;
   entry_type        req_ff;
   logic [8:0]       hops_ff;
   logic [16:0]      prod_ff;

   entry_type        cell_data  [QUEUE_DEPTH];
   logic             cell_valid [QUEUE_DEPTH];
   cell_ctl_type     cell_ctl   [QUEUE_DEPTH];
   entry_type        new_entry;

   logic             req_fire;
   logic [9:0]       routers;
   logic             bad_range;
   logic             full;
   logic             div_start;
   logic             div_busy_s;
   logic             div_busy_d;
   logic [7:0]       q_src;
   logic [7:0]       q_dst;
   logic [4:0]       r_src;
   logic [4:0]       r_dst;
   logic [7:0]       row_diff;
   logic [4:0]       col_diff;
   entry_type        scan_entry;
   logic             scan_hit;
   logic             scan_end;
   logic [48:0]      lat;
   logic [12:0]      lat_sat;
   logic [31:0]      del_in;
   logic [63:0]      sum_in;
   logic [12:0]      max_in;
   logic [CNT_W-1:0] count_dec;
   logic             out_free;
   logic             emit_fire;

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_fire  = (state_ff == S_EMIT) && out_free;

   assign routers   = 10'(rows_ff * cols_ff);
   assign bad_range = ({2'b0, req_tdata[7:0]} >= routers) || ({2'b0, req_tdata[15:8]} >= routers);
   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign div_start = req_fire && !req_tuser && !bad_range && !full;

   mhq_div u_div_src (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_tdata[7:0]),
      .divisor   (cols_ff),
      .busy      (div_busy_s),
      .quotient  (q_src),
      .remainder (r_src)
   );

   mhq_div u_div_dst (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_tdata[15:8]),
      .divisor   (cols_ff),
      .busy      (div_busy_d),
      .quotient  (q_dst),
      .remainder (r_dst)
   );

   assign row_diff = (q_src > q_dst) ? q_src - q_dst : q_dst - q_src;
   assign col_diff = (r_src > r_dst) ? r_src - r_dst : r_dst - r_src;

   always_comb begin
      new_entry = req_ff;
      new_entry.due_at = {1'b0, req_ff.sent_at} + 49'(prod_ff);
   end

   // packed chain: new tiles land at the fill count, removal pulls the tail down one slot
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type up_d;
      logic      up_v;
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign up_d = cell_data[i];
         assign up_v = 1'b0;
      end else begin : g_mid
         assign up_d = cell_data[i+1];
         assign up_v = cell_valid[i+1];
      end
      assign cell_ctl[i].load  = (state_ff == S_ADD) && (count_ff == CNT_W'(i));
      assign cell_ctl[i].shift = (state_ff == S_CAPTURE) && (IDX_W'(i) >= best_idx_ff);
      mhq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl[i]),
         .wr_data  (new_entry),
         .up_data  (up_d),
         .up_valid (up_v),
         .data     (cell_data[i]),
         .valid    (cell_valid[i])
      );
   end

   assign scan_entry = cell_data[scan_idx_ff];
   assign scan_hit   = (scan_entry.due_at <= {1'b0, req_ff.sent_at}) &&
                       (!best_found_ff || scan_entry.due_at < best_ff.due_at);
   assign scan_end   = CNT_W'(scan_idx_ff) == CNT_W'(count_ff - CNT_W'(1));

   assign lat     = best_ff.due_at - {1'b0, best_ff.sent_at};
   assign lat_sat = (lat > 49'(LMAX_SAT)) ? 13'(LMAX_SAT) : lat[12:0];
   assign del_in  = stat_del_ff + 32'd1;
   assign sum_in  = stat_sum_ff + 64'(lat);
   assign max_in  = (lat_sat > stat_max_ff) ? lat_sat : stat_max_ff;
   assign count_dec = count_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         emit_next_ff   <= S_IDLE;
         cols_ff        <= 5'd4;
         rows_ff        <= 5'd4;
         hop_lat_ff     <= 8'd1;
         count_ff       <= '0;
         stat_del_ff    <= '0;
         stat_sum_ff    <= '0;
         stat_max_ff    <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         best_found_ff  <= 1'b0;
         scan_idx_ff    <= '0;
         n_ff           <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_COLS:    cols_ff    <= csr_data[4:0];
               REG_ROWS:    rows_ff    <= csr_data[4:0];
               REG_HOP_LAT: hop_lat_ff <= csr_data;
               default: ;
            endcase
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  req_ff.src       <= req_tdata[7:0];
                  req_ff.dst       <= req_tdata[15:8];
                  req_ff.tile_id   <= req_tdata[31:16];
                  req_ff.tile_size <= req_tdata[63:32];
                  req_ff.sent_at   <= req_tdata[111:64];
                  req_ff.due_at    <= '0;
                  if (req_tuser) begin
                     n_ff          <= '0;
                     scan_idx_ff   <= '0;
                     best_found_ff <= 1'b0;
                     state_ff      <= (count_ff == '0) ? S_DECIDE : S_SCAN;
                  end else if (bad_range || full) begin
                     stage_ff.kind          <= KIND_INJECT;
                     stage_ff.status        <= bad_range ? STATUS_RANGE : STATUS_FULL;
                     stage_ff.entry         <= '0;
                     stage_ff.delivered     <= stat_del_ff;
                     stage_ff.latency_total <= stat_sum_ff;
                     stage_ff.latency_max   <= stat_max_ff;
                     stage_ff.last          <= 1'b1;
                     stage_valid_ff         <= 1'b1;
                     emit_next_ff           <= S_IDLE;
                     state_ff               <= S_EMIT;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (!div_busy_s && !div_busy_d) begin
                  hops_ff  <= {1'b0, row_diff} + 9'(col_diff);
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= 17'(hops_ff * hop_lat_ff);
               state_ff <= S_ADD;
            end
            S_ADD: begin
               count_ff               <= count_ff + CNT_W'(1);
               stage_ff.kind          <= KIND_INJECT;
               stage_ff.status        <= STATUS_OK;
               stage_ff.entry         <= '0;
               stage_ff.delivered     <= stat_del_ff;
               stage_ff.latency_total <= stat_sum_ff;
               stage_ff.latency_max   <= stat_max_ff;
               stage_ff.last          <= 1'b1;
               stage_valid_ff         <= 1'b1;
               emit_next_ff           <= S_IDLE;
               state_ff               <= S_EMIT;
            end
            S_SCAN: begin
               if (scan_hit) begin
                  best_ff       <= scan_entry;
                  best_idx_ff   <= scan_idx_ff;
                  best_found_ff <= 1'b1;
               end
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
               if (scan_end) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (best_found_ff && stage_valid_ff) begin
                  // earlier tile is not the last one: send it before taking this one
                  emit_next_ff <= S_CAPTURE;
                  state_ff     <= S_EMIT;
               end else if (best_found_ff) begin
                  state_ff <= S_CAPTURE;
               end else if (stage_valid_ff) begin
                  stage_ff.last <= 1'b1;
                  emit_next_ff  <= S_IDLE;
                  state_ff      <= S_EMIT;
               end else begin
                  stage_ff.kind          <= KIND_IDLE;
                  stage_ff.status        <= STATUS_OK;
                  stage_ff.entry         <= '0;
                  stage_ff.delivered     <= stat_del_ff;
                  stage_ff.latency_total <= stat_sum_ff;
                  stage_ff.latency_max   <= stat_max_ff;
                  stage_ff.last          <= 1'b1;
                  stage_valid_ff         <= 1'b1;
                  emit_next_ff           <= S_IDLE;
                  state_ff               <= S_EMIT;
               end
            end
            S_CAPTURE: begin
               stat_del_ff            <= del_in;
               stat_sum_ff            <= sum_in;
               stat_max_ff            <= max_in;
               stage_ff.kind          <= KIND_DELIVER;
               stage_ff.status        <= STATUS_OK;
               stage_ff.entry         <= best_ff;
               stage_ff.delivered     <= del_in;
               stage_ff.latency_total <= sum_in;
               stage_ff.latency_max   <= max_in;
               stage_valid_ff         <= 1'b1;
               count_ff               <= count_dec;
               n_ff                   <= n_ff + N_W'(1);
               best_found_ff          <= 1'b0;
               scan_idx_ff            <= '0;
               if (n_ff == N_W'(OUT_LIMIT - 1)) begin
                  stage_ff.last <= 1'b1;
                  emit_next_ff  <= S_IDLE;
                  state_ff      <= S_EMIT;
               end else begin
                  stage_ff.last <= 1'b0;
                  state_ff      <= (count_dec == '0) ? S_DECIDE : S_SCAN;
               end
            end
            S_EMIT: begin
               if (emit_fire) begin
                  rsp_ff         <= stage_ff;
                  stage_valid_ff <= 1'b0;
                  state_ff       <= emit_next_ff;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {rsp_ff.latency_max, rsp_ff.latency_total, rsp_ff.delivered,
                        rsp_ff.entry.due_at, rsp_ff.entry.sent_at,
                        rsp_ff.entry.dst, rsp_ff.entry.src, rsp_ff.entry.tile_size,
                        rsp_ff.entry.tile_id, rsp_ff.status};

   logic [CNT_W-1:0] valid_ones;
   always_comb begin
      valid_ones = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         valid_ones = valid_ones + CNT_W'(cell_valid[i]);
      end
   end

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == valid_ones)
      else $error("fill count differs from valid cells");

   a_idle_stage_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !stage_valid_ff)
      else $error("staged result left behind in idle");

   a_capture_removes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CAPTURE |=> count_ff == $past(count_dec))
      else $error("delivery did not remove one entry");

endmodule

FILE: verif/tb.sv
// testbench for the mesh hop latency delivery queue: directed and random beats, scoreboard check
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mhq_pkg::*;

   localparam logic ACT_INJECT = 1'b0;
   localparam logic ACT_TICK   = 1'b1;
   localparam int   DEPTH      = 16;
   localparam int   IDLE_LIMIT = 6000;
   localparam int   HOLD_LEN   = 400;

   typedef struct {
      logic [1:0]  kind;
      logic [1:0]  status;
      entry_type   tile;
      logic        last;
      logic [31:0] delivered;
      logic [63:0] lat_total;
      logic [12:0] lat_max;
   } outcome_type;

   class delivery_scoreboard;
      logic [4:0]  cols = 5'd4;
      logic [4:0]  rows = 5'd4;
      logic [7:0]  hop_lat = 8'd1;
      entry_type   pending_tiles[$];
      logic [31:0] delivered = '0;
      logic [63:0] lat_total = '0;
      logic [12:0] lat_max = '0;
      outcome_type awaited[$];
      int          errors, n_inject, n_range, n_full, n_deliver, n_idle, n_checked;

      function void set_reg(logic [1:0] idx, logic [7:0] val);
         if (idx == REG_COLS) cols = val[4:0];
         else if (idx == REG_ROWS) rows = val[4:0];
         else if (idx == REG_HOP_LAT) hop_lat = val;
      endfunction

      function outcome_type stats_only(logic [1:0] kind, logic [1:0] status);
         outcome_type o;
         o.kind = kind;
         o.status = status;
         o.tile = '0;
         o.last = 1'b1;
         o.delivered = delivered;
         o.lat_total = lat_total;
         o.lat_max = lat_max;
         return o;
      endfunction

      function void note_request(logic act, logic [7:0] src, logic [7:0] dst,
                                 logic [15:0] id, logic [31:0] size, logic [47:0] cyc);
         int routers, hops, best, n;
         entry_type e;
         outcome_type o;
         logic [63:0] lat;
         routers = int'(rows) * int'(cols);
         if (act == ACT_INJECT) begin
            if (src >= routers || dst >= routers) begin
               awaited.push_back(stats_only(KIND_INJECT, STATUS_RANGE));
               n_range++;
            end else if (pending_tiles.size() >= DEPTH) begin
               awaited.push_back(stats_only(KIND_INJECT, STATUS_FULL));
               n_full++;
            end else begin
               hops = ((src / cols > dst / cols) ? src / cols - dst / cols
                                                 : dst / cols - src / cols)
                    + ((src % cols > dst % cols) ? src % cols - dst % cols
                                                 : dst % cols - src % cols);
               e.tile_id = id;
               e.tile_size = size;
               e.src = src;
               e.dst = dst;
               e.sent_at = cyc;
               e.due_at = {1'b0, cyc} + 49'(hops * int'(hop_lat));
               pending_tiles.push_back(e);
               awaited.push_back(stats_only(KIND_INJECT, STATUS_OK));
               n_inject++;
            end
            return;
         end
         n = 0;
         while (n < OUT_LIMIT) begin
            best = -1;
            foreach (pending_tiles[i])
               if (pending_tiles[i].due_at <= {1'b0, cyc} && (best < 0 ||
                   pending_tiles[i].due_at < pending_tiles[best].due_at))
                  best = i;
            if (best < 0) break;
            e = pending_tiles[best];
            lat = 64'(e.due_at) - 64'(e.sent_at);
            delivered++;
            lat_total += lat;
            if (lat > LMAX_SAT) lat = LMAX_SAT;
            if (lat[12:0] > lat_max) lat_max = lat[12:0];
            o = stats_only(KIND_DELIVER, STATUS_OK);
            o.tile = e;
            o.last = 1'b0;
            awaited.push_back(o);
            pending_tiles.delete(best);
            n++;
            n_deliver++;
         end
         if (n == 0) begin
            awaited.push_back(stats_only(KIND_IDLE, STATUS_OK));
            n_idle++;
         end else begin
            awaited[$].last = 1'b1;
         end
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch on result %0d: %s got %0h want %0h", n_checked, what, got, want);
      endtask

      task field(string what, logic [63:0] got, logic [63:0] want);
         if (got !== want) report(what, got, want);
      endtask

      task check_result(outcome_type g);
         outcome_type w;
         if (awaited.size() == 0) begin
            report("unexpected beat kind", 64'(g.kind), 64'hx);
            return;
         end
         w = awaited.pop_front();
         field("result_kind", g.kind, w.kind);
         field("status", g.status, w.status);
         field("tile_id", g.tile.tile_id, w.tile.tile_id);
         field("tile_size", g.tile.tile_size, w.tile.tile_size);
         field("src", g.tile.src, w.tile.src);
         field("dst", g.tile.dst, w.tile.dst);
         field("sent_at", g.tile.sent_at, w.tile.sent_at);
         field("due_at", g.tile.due_at, w.tile.due_at);
         field("last", g.last, w.last);
         field("delivered", g.delivered, w.delivered);
         field("latency_total", g.lat_total, w.lat_total);
         field("latency_max", g.lat_max, w.lat_max);
         n_checked++;
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [271:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [7:0]   csr_data = '0;

   delivery_scoreboard sb = new();
   bit          no_gaps;
   bit          hold_req;
   bit          hold_done;
   int          idle_cycles;
   logic [47:0] base_cyc;

   mesh_hop_latency_delivery_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (.*);

   always #2 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: sample at the rising edge, choose ready at the falling edge
   initial begin
      int stall;
      outcome_type g;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready && !reset) begin
            g.status = rsp_tdata[1:0];
            g.tile.tile_id = rsp_tdata[17:2];
            g.tile.tile_size = rsp_tdata[49:18];
            g.tile.src = rsp_tdata[57:50];
            g.tile.dst = rsp_tdata[65:58];
            g.tile.sent_at = rsp_tdata[113:66];
            g.tile.due_at = rsp_tdata[162:114];
            g.delivered = rsp_tdata[194:163];
            g.lat_total = rsp_tdata[258:195];
            g.lat_max = rsp_tdata[271:259];
            g.kind = rsp_tuser;
            g.last = rsp_tlast;
            sb.check_result(g);
         end
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
         end
         if (stall > 0) begin
            stall--;
            rsp_tready = 1'b0;
         end else begin
            stall = pick_gap();
            rsp_tready = (stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send(logic act, logic [7:0] src, logic [7:0] dst, logic [15:0] id,
                       logic [31:0] size, logic [47:0] cyc);
      int g;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = act;
      req_tdata = {cyc, size, id, dst, src};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, src, dst, id, size, cyc);
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(logic [7:0] c, logic [7:0] r, logic [7:0] h);
      wait_drained();
      write_reg(REG_COLS, c);
      write_reg(REG_ROWS, r);
      write_reg(REG_HOP_LAT, h);
   endtask

   task automatic random_item();
      int r, top;
      logic [7:0] s, d;
      r = $urandom_range(0, 99);
      top = int'(sb.rows) * int'(sb.cols);
      top = (top > 256 ? 256 : top) - 1;
      if ($urandom_range(0, 19) == 0)
         base_cyc = 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_0000;
      base_cyc += $urandom_range(0, 12);
      if (r < 62) begin
         s = 8'($urandom_range(0, top));
         d = 8'($urandom_range(0, top));
         send(ACT_INJECT, s, d, 16'($urandom), $urandom, base_cyc);
      end else if (r < 88) begin
         send(ACT_TICK, 8'($urandom), 8'($urandom), 16'($urandom), $urandom,
              base_cyc + $urandom_range(0, 3 * int'(sb.hop_lat) + 20));
      end else begin
         send(1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), $urandom,
              48'({$urandom, $urandom}));
      end
   endtask

   initial begin
      logic [7:0] ph_cols[6] = '{8'd4, 8'd16, 8'd1, 8'd31, 8'd8, 8'd2};
      logic [7:0] ph_rows[6] = '{8'd4, 8'd16, 8'd31, 8'd1, 8'd255, 8'd3};
      logic [7:0] ph_hop[6]  = '{8'd1, 8'd0, 8'd255, 8'd7, 8'd3, 8'd20};
      base_cyc = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset geometry 4x4, hop latency register at its reset value
      send(ACT_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 48'd0);
      send(ACT_INJECT, 8'd16, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 48'd5);
      send(ACT_INJECT, 8'd3, 8'd255, 16'd1, 32'd1, 48'd5);
      for (int i = 0; i < 16; i++)
         send(ACT_INJECT, 8'(i), 8'(15 - i), (i == 0) ? 16'h0 : 16'hFFFF - 16'(i),
              (i == 1) ? 32'hFFFF_FFFF : 32'(i * 77), 48'd100);
      send(ACT_INJECT, 8'd0, 8'd1, 16'd9, 32'd9, 48'd100);
      send(ACT_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 48'd50);
      send(ACT_TICK, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);

      // latency above the saturation point, then zero columns
      configure(8'd8, 8'd31, 8'd255);
      send(ACT_INJECT, 8'd0, 8'd247, 16'h1234, 32'h5678, 48'hFFFF_FFFF_FFFF);
      send(ACT_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
      send(ACT_TICK, 8'd0, 8'd0, 16'd0, 32'd0, 48'd0);
      configure(8'd0, 8'd4, 8'd1);
      send(ACT_INJECT, 8'd0, 8'd0, 16'd5, 32'd5, 48'd7);

      for (int p = 0; p < 6; p++) begin
         configure(ph_cols[p], ph_rows[p], ph_hop[p]);
         no_gaps = (p == 3);
         if (p == 1) hold_req = 1'b1;
         for (int k = 0; k < 18; k++) random_item();
      end
      no_gaps = 1'b0;

      wait_drained();
      $display("covered %0d accepted injects, %0d out of range, %0d full, %0d deliveries,",
               sb.n_inject, sb.n_range, sb.n_full, sb.n_deliver);
      $display("%0d empty ticks over 8 register settings; %0d results checked",
               sb.n_idle, sb.n_checked);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/mhq_pkg.sv
rtl/mhq_cell.sv
rtl/mhq_div.sv
rtl/mesh_hop_latency_delivery_queue_unit.sv
verif/tb.sv
